### design/ibc_pkg.sv
// ============================================================================
// ibc_pkg
// Shared widths, codes and controller/datapath interface types for the
// six-axis bias calibration and correction block.
// ============================================================================
`default_nettype none

package ibc_pkg;

    // Frame geometry
    localparam int NUM_AXES  = 6;
    localparam int AXIS_W    = $clog2(NUM_AXES);
    localparam int DATA_W    = 16;
    localparam int SUM_W     = 32;
    localparam int GRAV_W    = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Divider: one quotient bit per cycle over the full sum width
    localparam int BIT_CNT_W = $clog2(SUM_W);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(SUM_W - 1);
    localparam logic [AXIS_W-1:0]    AXIS_LAST = AXIS_W'(NUM_AXES - 1);
    localparam logic [AXIS_W-1:0]    AXIS_ACCEL_Z = AXIS_W'(2);

    // Register defaults
    localparam logic [CFG_W-1:0]  DEFAULT_CAL_SAMPLES = 16'd1000;
    localparam logic [GRAV_W-1:0] DEFAULT_GRAVITY_LSB = 15'd8192;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_LSB = 2'd1;

    // Action codes (both remaining codes abort)
    localparam logic [1:0] ACT_CORRECT = 2'd0;
    localparam logic [1:0] ACT_CAL     = 2'd1;

    // Status codes
    localparam logic [1:0] STATUS_CORR  = 2'd0;
    localparam logic [1:0] STATUS_TAKEN = 2'd1;
    localparam logic [1:0] STATUS_DONE  = 2'd2;
    localparam logic [1:0] STATUS_ABORT = 2'd3;

    typedef logic signed [DATA_W-1:0] sample_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              accum;      // add frame into sums
        logic              clear_cal;  // clear sums and frame count
        logic              load_div;   // load divider from current axis sum
        logic              step_div;   // one quotient bit
        logic              store_axis; // write quotient as offset of current axis
        logic [AXIS_W-1:0] axis;
        logic              out_load;   // capture a result into the output register
        logic [1:0]        out_status;
    } ibc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_frame; // next calibration frame completes the calibration
    } ibc_stat_t;

endpackage

`default_nettype wire

### design/ibc_dp.sv
// ============================================================================
// ibc_dp
// Datapath: configuration registers, per-axis sums and frame count, offset
// store, shared restoring divider and the result register.
// ============================================================================
`default_nettype none

module ibc_dp (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ibc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ibc_pkg::CFG_W-1:0]   cfg_data,
    input  wire ibc_pkg::sample_t            samp_in [ibc_pkg::NUM_AXES],
    input  wire ibc_pkg::ibc_cmd_t           cmd,
    output ibc_pkg::ibc_stat_t               stat,
    output logic [1:0]                       status_out,
    output ibc_pkg::sample_t                 corr_out [ibc_pkg::NUM_AXES]
);
    import ibc_pkg::*;

    logic [CFG_W-1:0]       cal_samples_reg;
    logic [GRAV_W-1:0]      gravity_lsb_reg;
    logic [CFG_W-1:0]       n_eff;
    logic signed [SUM_W-1:0] sums_reg [NUM_AXES];
    logic [CFG_W-1:0]       frames_reg;
    sample_t                offsets_reg [NUM_AXES];
    logic [SUM_W-1:0]       dvd_reg;
    logic [CFG_W-1:0]       rem_reg;
    logic                   neg_reg;
    logic signed [SUM_W-1:0] cur_sum;
    logic [CFG_W:0]         trial;
    logic [CFG_W:0]         diff;
    logic [DATA_W-1:0]      q_signed;
    logic [DATA_W-1:0]      offset_next;
    logic [1:0]             status_reg;
    sample_t                corr_reg [NUM_AXES];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= DEFAULT_CAL_SAMPLES;
            gravity_lsb_reg <= DEFAULT_GRAVITY_LSB;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CAL_SAMPLES)
                cal_samples_reg <= cfg_data;
            else if (cfg_index == REG_GRAVITY_LSB)
                gravity_lsb_reg <= cfg_data[GRAV_W-1:0];
        end
    end

    // Effective frame count, zero meaning the default
    assign n_eff = (cal_samples_reg == '0) ? DEFAULT_CAL_SAMPLES : cal_samples_reg;
    assign stat.last_frame = ({1'b0, frames_reg} + 17'd1) >= {1'b0, n_eff};

    // Accumulation and frame count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                sums_reg[i] <= '0;
            frames_reg <= '0;
        end
        else if (cmd.clear_cal)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                sums_reg[i] <= '0;
            frames_reg <= '0;
        end
        else if (cmd.accum)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                sums_reg[i] <= sums_reg[i] + SUM_W'(samp_in[i]);
            // the final frame leaves its sums for the divider
            frames_reg <= stat.last_frame ? '0 : frames_reg + 16'd1;
        end
    end

    // Restoring divider step on the magnitude of the selected sum
    assign cur_sum = sums_reg[cmd.axis];
    assign trial   = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff    = trial - {1'b0, n_eff};

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            neg_reg <= cur_sum[SUM_W-1];
            dvd_reg <= cur_sum[SUM_W-1] ? (SUM_W'(0) - cur_sum) : cur_sum;
            rem_reg <= '0;
        end
        else if (cmd.step_div)
        begin
            if (!diff[CFG_W])
            begin
                rem_reg <= diff[CFG_W-1:0];
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CFG_W-1:0];
                dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    // Truncated average, wrapped; accel Z also drops one g
    assign q_signed    = neg_reg ? (DATA_W'(0) - dvd_reg[DATA_W-1:0]) : dvd_reg[DATA_W-1:0];
    assign offset_next = (cmd.axis == AXIS_ACCEL_Z) ?
                         (q_signed - {1'b0, gravity_lsb_reg}) : q_signed;

    // Offset store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                offsets_reg[i] <= '0;
        end
        else if (cmd.store_axis)
        begin
            offsets_reg[cmd.axis] <= offset_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            for (int i = 0; i < NUM_AXES; i++)
                corr_reg[i] <= (cmd.out_status == STATUS_CORR) ?
                               sample_t'(samp_in[i] - offsets_reg[i]) : '0;
        end
    end

    assign status_out = status_reg;
    assign corr_out   = corr_reg;

endmodule

`default_nettype wire

### design/ibc_ctrl.sv
// ============================================================================
// ibc_ctrl
// Controller: input/output handshakes, action decode and sequencing of the
// per-axis division at the end of a calibration.
// ============================================================================
`default_nettype none

module ibc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         action,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire ibc_pkg::ibc_stat_t stat,
    output ibc_pkg::ibc_cmd_t       cmd
);
    import ibc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_STORE,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [AXIS_W-1:0]     axis_cnt_reg;
    logic                  out_valid_reg;
    logic                  out_free;
    logic                  take;

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = (state_reg == S_IDLE) && in_valid && out_free;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign out_valid = out_valid_reg;

    // Command decode and next state
    always_comb
    begin
        cmd            = '0;
        cmd.axis       = axis_cnt_reg;
        cmd.out_status = STATUS_CORR;
        state_next     = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    unique case (action)
                        ACT_CORRECT:
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = STATUS_CORR;
                        end
                        ACT_CAL:
                        begin
                            cmd.accum = 1'b1;
                            if (stat.last_frame)
                                state_next = S_LOAD;
                            else
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = STATUS_TAKEN;
                            end
                        end
                        default:
                        begin
                            cmd.clear_cal  = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_status = STATUS_ABORT;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_div = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.step_div = 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.store_axis = 1'b1;
                state_next     = (axis_cnt_reg == AXIS_LAST) ? S_DONE : S_LOAD;
            end
            S_DONE:
            begin
                // sums are released once the result can be posted
                if (out_free)
                begin
                    cmd.clear_cal  = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STATUS_DONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            axis_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_div)
                bit_cnt_reg <= '0;
            else if (cmd.step_div)
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            if (take)
                axis_cnt_reg <= '0;
            else if (cmd.store_axis && (axis_cnt_reg != AXIS_LAST))
                axis_cnt_reg <= axis_cnt_reg + 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Checks
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a held result");

    a_div_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_div |=> (bit_cnt_reg == '0 && state_reg == S_DIV))
        else $error("divider not restarted on axis load");

    a_last_axis_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.store_axis && axis_cnt_reg == AXIS_LAST) |=> state_reg == S_DONE)
        else $error("calibration did not finish after last axis");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !(cmd.accum || cmd.store_axis && cmd.load_div))
        else $error("frame taken while dividing");

endmodule

`default_nettype wire

### design/imu_bias_calibrate_correct.sv
// ============================================================================
// imu_bias_calibrate_correct
// Six-axis IMU bias calibration by averaging, and per-frame offset
// correction.
// ============================================================================
// Correct, calibration and abort frames each leave one result in an output
// register, so a new frame is taken in the cycle after the last as long as
// the result side keeps up. The calibration frame that reaches the
// configured count starts a shared restoring divider that produces one
// quotient bit per cycle and works through the six axes in turn; input
// stays stalled until that frame's "calibration done" result appears.
// ============================================================================
`default_nettype none

module imu_bias_calibrate_correct (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [ibc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ibc_pkg::CFG_W-1:0]       cfg_data,
    // input frames
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      action,
    input  wire logic signed [ibc_pkg::DATA_W-1:0] accel_x,
    input  wire logic signed [ibc_pkg::DATA_W-1:0] accel_y,
    input  wire logic signed [ibc_pkg::DATA_W-1:0] accel_z,
    input  wire logic signed [ibc_pkg::DATA_W-1:0] gyro_x,
    input  wire logic signed [ibc_pkg::DATA_W-1:0] gyro_y,
    input  wire logic signed [ibc_pkg::DATA_W-1:0] gyro_z,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr_accel_x,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr_accel_y,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr_accel_z,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr_gyro_x,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr_gyro_y,
    output logic signed [ibc_pkg::DATA_W-1:0]    corr_gyro_z
);
    import ibc_pkg::*;

    ibc_cmd_t  cmd;
    ibc_stat_t stat;
    sample_t   samp [NUM_AXES];
    sample_t   corr [NUM_AXES];

    // Frame order: ax ay az gx gy gz
    assign samp[0] = accel_x;
    assign samp[1] = accel_y;
    assign samp[2] = accel_z;
    assign samp[3] = gyro_x;
    assign samp[4] = gyro_y;
    assign samp[5] = gyro_z;

    assign corr_accel_x = corr[0];
    assign corr_accel_y = corr[1];
    assign corr_accel_z = corr[2];
    assign corr_gyro_x  = corr[3];
    assign corr_gyro_y  = corr[4];
    assign corr_gyro_z  = corr[5];

    ibc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ibc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .samp_in    (samp),
        .cmd        (cmd),
        .stat       (stat),
        .status_out (status),
        .corr_out   (corr)
    );

endmodule

`default_nettype wire
